/* rtl/dsk_pkg.sv */
// Shared types and constants for the dual servo PWM block.
`timescale 1ns / 1ps

package dsk_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_KEYS  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_PERIOD  = 2'd0,
        REG_FLOOR   = 2'd1,
        REG_CEILING = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    localparam logic [15:0] PERIOD_RESET    = 16'd200;
    localparam logic [15:0] FLOOR_RESET     = 16'd5;
    localparam logic [15:0] CEILING_RESET   = 16'd23;
    localparam logic [15:0] DUTY_RESET      = 16'd5;
    localparam logic [31:0] DUTY_WORD_RESET = 32'h0005_0005;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] floor_duty;
        logic [15:0] ceiling_duty;
    } t_cfg;

    typedef struct packed {
        logic tick;
        logic key_dn;
        logic key_up;
    } t_chan_ctrl;

    typedef struct packed {
        logic        level;
        logic        duty_set;
        logic [15:0] duty;
    } t_chan_stat;

endpackage

/* rtl/dsk_channel.sv */
// One PWM channel: on/off counters, active duty, pin level and key steps.
`timescale 1ns / 1ps

module dsk_channel
    import dsk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_chan_ctrl  i_ctrl,
    input  logic [15:0] i_pending,
    output t_chan_stat  o_stat
);

    logic [15:0] r_on;
    logic [15:0] r_off;
    logic [15:0] r_duty;
    logic        r_level;

    logic [15:0] n_on;
    logic [15:0] n_off;
    logic [15:0] n_duty;
    logic        n_level;
    logic        key_dn_hit;
    logic        key_up_hit;
    logic [15:0] duty_mid;
    logic [16:0] frame_sum;

    always_comb begin
        n_on       = r_on;
        n_off      = r_off;
        n_duty     = r_duty;
        n_level    = r_level;
        key_dn_hit = 1'b0;
        key_up_hit = 1'b0;
        duty_mid   = r_duty;
        frame_sum  = 17'd0;
        if (i_ctrl.tick) begin
            if (r_on < r_duty) begin
                n_level = 1'b1;
                n_on    = r_on + 16'd1;
            end else begin
                n_level = 1'b0;
                n_off   = r_off + 16'd1;
            end
            // The frame ends once the two counts together reach the period.
            frame_sum = {1'b0, n_on} + {1'b0, n_off};
            if (frame_sum >= {1'b0, i_cfg.period}) begin
                n_on   = 16'd0;
                n_off  = 16'd0;
                n_duty = i_pending;
            end
        end else begin
            // Down is applied before up, and up sees the result of down.
            key_dn_hit = i_ctrl.key_dn && (r_duty > i_cfg.floor_duty);
            if (key_dn_hit) begin
                duty_mid = r_duty - 16'd1;
            end
            key_up_hit = i_ctrl.key_up && (duty_mid < i_cfg.ceiling_duty);
            n_duty = key_up_hit ? duty_mid + 16'd1 : duty_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on    <= 16'd0;
            r_off   <= 16'd0;
            r_duty  <= DUTY_RESET;
            r_level <= 1'b0;
        end else begin
            r_on    <= n_on;
            r_off   <= n_off;
            r_duty  <= n_duty;
            r_level <= n_level;
        end
    end

    assign o_stat.level    = n_level;
    assign o_stat.duty_set = key_dn_hit || key_up_hit;
    assign o_stat.duty     = n_duty;

endmodule

/* rtl/dual_servo_pwm_with_keys.sv */
// Top level of the two-channel servo PWM generator with key duty control.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------------------
//  request  | in        | i_in_valid / o_in_stall   | i_operation, i_key_edges, i_write_word
//  result   | out       | o_out_valid / i_out_stall | o_motor1_level, o_motor2_level,
//           |           |                           | o_duty_word_out
//  config   | in        | psel, penable, pwrite     | paddr, pwdata, prdata (pready high)
//
// A request is registered, then worked into the result register, so one request
// per cycle is taken while the result is not stalled; a result is valid once it
// sits in the result register and can leave whenever the output is not stalled.
// A stalled result holds the result register; an empty input register still
// takes one request, and a full one stalls the input. Reset is synchronous.
`timescale 1ns / 1ps

module dual_servo_pwm_with_keys
    import dsk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_key_edges,
    input  logic [31:0] i_write_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_motor1_level,
    output logic        o_motor2_level,
    output logic [31:0] o_duty_word_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    t_op         r_op;
    logic [3:0]  r_keys;
    logic [31:0] r_wword;
    logic [31:0] r_duty_word;
    logic        r_out_valid;
    logic        r_m1;
    logic        r_m2;
    logic [31:0] r_out_word;

    logic        advance;
    logic        work;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic [31:0] n_duty_word;
    t_chan_ctrl  ctrl_one;
    t_chan_ctrl  ctrl_two;
    t_chan_stat  stat_one;
    t_chan_stat  stat_two;

    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_PERIOD:  prdata = {16'd0, r_cfg.period};
            REG_FLOOR:   prdata = {16'd0, r_cfg.floor_duty};
            REG_CEILING: prdata = {16'd0, r_cfg.ceiling_duty};
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period       <= PERIOD_RESET;
            r_cfg.floor_duty   <= FLOOR_RESET;
            r_cfg.ceiling_duty <= CEILING_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PERIOD:  r_cfg.period       <= pwdata[15:0];
                REG_FLOOR:   r_cfg.floor_duty   <= pwdata[15:0];
                REG_CEILING: r_cfg.ceiling_duty <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    // The pipe moves whenever the result register is empty or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign work       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_op    <= t_op'(i_operation);
            r_keys  <= i_key_edges;
            r_wword <= i_write_word;
        end
    end

    assign ctrl_one.tick   = work && (r_op == OP_TICK);
    assign ctrl_one.key_dn = work && (r_op == OP_KEYS) && r_keys[0];
    assign ctrl_one.key_up = work && (r_op == OP_KEYS) && r_keys[1];
    assign ctrl_two.tick   = work && (r_op == OP_TICK);
    assign ctrl_two.key_dn = work && (r_op == OP_KEYS) && r_keys[2];
    assign ctrl_two.key_up = work && (r_op == OP_KEYS) && r_keys[3];

    dsk_channel u_chan_one (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_ctrl    (ctrl_one),
        .i_pending (r_duty_word[15:0]),
        .o_stat    (stat_one)
    );

    dsk_channel u_chan_two (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_ctrl    (ctrl_two),
        .i_pending (r_duty_word[31:16]),
        .o_stat    (stat_two)
    );

    always_comb begin
        n_duty_word = r_duty_word;
        if (work) begin
            unique case (r_op)
                OP_WRITE: n_duty_word = r_wword;
                OP_KEYS: begin
                    if (stat_one.duty_set) begin
                        n_duty_word[15:0] = stat_one.duty;
                    end
                    if (stat_two.duty_set) begin
                        n_duty_word[31:16] = stat_two.duty;
                    end
                end
                OP_TICK, OP_READ: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_word <= DUTY_WORD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_duty_word <= n_duty_word;
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_m1       <= stat_one.level;
            r_m2       <= stat_two.level;
            r_out_word <= n_duty_word;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor1_level  = r_m1;
    assign o_motor2_level  = r_m2;
    assign o_duty_word_out = r_out_word;

endmodule

/* tb/sv/dsk_pwm_checker.sv */
// Checker that predicts the pin levels and duty word of each request and compares them.
`timescale 1ns / 1ps

module dsk_pwm_checker
    import dsk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_key_edges,
    input  logic [31:0] i_write_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_motor1_level,
    input  logic        i_motor2_level,
    input  logic [31:0] i_duty_word_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_mismatches,
    output int          o_pending
);

    typedef struct packed {
        logic        motor1;
        logic        motor2;
        logic [31:0] duty_word;
    } t_pwm_out;

    t_cfg        cfg;
    logic [31:0] duty_word;
    logic [15:0] active_duty [2];
    logic [15:0] on_cnt [2];
    logic [15:0] off_cnt [2];
    logic [1:0]  pins;
    t_pwm_out    pwm_outputs_q [$];
    int          err_count = 0;

    assign o_mismatches = err_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: ERROR %s: got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // The pin level is decided before the frame is checked for its end, so a
    // zero period still yields one level per tick.
    function automatic logic tick_motor(input int m, input logic [15:0] next_duty);
        logic        level;
        logic [16:0] frame_len;
        level = (on_cnt[m] < active_duty[m]);
        if (level) begin
            on_cnt[m] = on_cnt[m] + 16'd1;
        end else begin
            off_cnt[m] = off_cnt[m] + 16'd1;
        end
        frame_len = {1'b0, on_cnt[m]} + {1'b0, off_cnt[m]};
        if (frame_len >= {1'b0, cfg.period}) begin
            on_cnt[m]      = '0;
            off_cnt[m]     = '0;
            active_duty[m] = next_duty;
        end
        return level;
    endfunction

    // Keys act in order: motor 1 down, motor 1 up, motor 2 down, motor 2 up.
    function automatic void step_keys(input logic [3:0] keys);
        for (int m = 0; m < 2; m++) begin
            if (keys[2*m] && active_duty[m] > cfg.floor_duty) begin
                active_duty[m]        = active_duty[m] - 16'd1;
                duty_word[16*m +: 16] = active_duty[m];
            end
            if (keys[2*m+1] && active_duty[m] < cfg.ceiling_duty) begin
                active_duty[m]        = active_duty[m] + 16'd1;
                duty_word[16*m +: 16] = active_duty[m];
            end
        end
    endfunction

    function automatic t_pwm_out predict_pwm(input t_op op, input logic [3:0] keys,
                                             input logic [31:0] word);
        logic l1;
        logic l2;
        case (op)
            OP_TICK: begin
                l1   = tick_motor(0, duty_word[15:0]);
                l2   = tick_motor(1, duty_word[31:16]);
                pins = {l2, l1};
            end
            OP_KEYS:  step_keys(keys);
            OP_WRITE: duty_word = word;
            default: ;
        endcase
        return '{motor1: pins[0], motor2: pins[1], duty_word: duty_word};
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_pwm_out    want;
        t_reg_idx    reg_idx;
        logic [15:0] reg_val;
        if (!i_rst_n) begin
            cfg = '{period: PERIOD_RESET, floor_duty: FLOOR_RESET,
                    ceiling_duty: CEILING_RESET};
            duty_word = DUTY_WORD_RESET;
            for (int m = 0; m < 2; m++) begin
                active_duty[m] = DUTY_RESET;
                on_cnt[m]      = '0;
                off_cnt[m]     = '0;
            end
            pins = '0;
            pwm_outputs_q.delete();
        end else begin
            // Results leave only after their request has been registered, so pop before push.
            if (i_out_valid && !i_out_stall) begin
                if (pwm_outputs_q.size() == 0) begin
                    report_mismatch("result with no request waiting", i_duty_word_out, '0);
                end else begin
                    want = pwm_outputs_q.pop_front();
                    if (i_motor1_level !== want.motor1) begin
                        report_mismatch("motor1_level", 32'(i_motor1_level),
                                        32'(want.motor1));
                    end
                    if (i_motor2_level !== want.motor2) begin
                        report_mismatch("motor2_level", 32'(i_motor2_level),
                                        32'(want.motor2));
                    end
                    if (i_duty_word_out !== want.duty_word) begin
                        report_mismatch("duty_word_out", i_duty_word_out, want.duty_word);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pwm_outputs_q.push_back(predict_pwm(t_op'(i_operation), i_key_edges,
                                                    i_write_word));
            end
            if (i_psel && i_penable && i_pready) begin
                reg_idx = t_reg_idx'(i_paddr[3:2]);
                if (reg_idx != REG_NONE) begin
                    if (i_pwrite) begin
                        case (reg_idx)
                            REG_PERIOD: cfg.period       = i_pwdata[15:0];
                            REG_FLOOR:  cfg.floor_duty   = i_pwdata[15:0];
                            default:    cfg.ceiling_duty = i_pwdata[15:0];
                        endcase
                    end else begin
                        case (reg_idx)
                            REG_PERIOD: reg_val = cfg.period;
                            REG_FLOOR:  reg_val = cfg.floor_duty;
                            default:    reg_val = cfg.ceiling_duty;
                        endcase
                        if (i_prdata[15:0] !== reg_val) begin
                            report_mismatch("register read", i_prdata, 32'(reg_val));
                        end
                    end
                end
            end
        end
        o_pending <= pwm_outputs_q.size();
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top: drives requests, register accesses and result stalls, and gives the verdict.
`timescale 1ns / 1ps

module tb;
    import dsk_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_REQUESTS = 80;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [1:0]  i_operation  = OP_TICK;
    logic [3:0]  i_key_edges  = '0;
    logic [31:0] i_write_word = '0;
    logic        i_out_stall  = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_motor1_level;
    logic        o_motor2_level;
    logic [31:0] o_duty_word_out;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          idle_pct     = 0;
    int          stall_left   = 0;
    int          quiet_cycles = 0;
    logic [15:0] cur_period   = PERIOD_RESET;

    always #4 i_clk = ~i_clk;

    dual_servo_pwm_with_keys DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_key_edges     (i_key_edges),
        .i_write_word    (i_write_word),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_motor1_level  (o_motor1_level),
        .o_motor2_level  (o_motor2_level),
        .o_duty_word_out (o_duty_word_out),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    dsk_pwm_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_key_edges     (i_key_edges),
        .i_write_word    (i_write_word),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_motor1_level  (o_motor1_level),
        .i_motor2_level  (o_motor2_level),
        .i_duty_word_out (o_duty_word_out),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // Result stalls come in random bursts.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 2) begin
            stall_left  <= $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input t_op op, input logic [3:0] keys,
                                input logic [31:0] word);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_key_edges  <= keys;
        i_write_word <= word;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic is_write, input t_reg_idx idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Upper data bits are random; only the low half belongs to each register.
    task automatic set_config(input logic [15:0] period, input logic [15:0] floor_duty,
                              input logic [15:0] ceiling_duty);
        reg_access(1'b1, REG_PERIOD, {16'($urandom), period});
        reg_access(1'b1, REG_FLOOR, {16'($urandom), floor_duty});
        reg_access(1'b1, REG_CEILING, {16'($urandom), ceiling_duty});
        reg_access(1'b0, t_reg_idx'($urandom_range(0, 2)), '0);
        cur_period = period;
    endtask

    // Duties mostly fall from zero to just above the period so frames show both levels and full-high.
    function automatic logic [15:0] pick_duty();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            return 16'($urandom);
        end
        if (pick == 1) begin
            return 16'd0;
        end
        return 16'($urandom_range(0, int'(cur_period) + 2));
    endfunction

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            send_request(OP_TICK, 4'($urandom), $urandom);
        end else if (pick < 80) begin
            send_request(OP_KEYS, 4'($urandom), $urandom);
        end else if (pick < 90) begin
            send_request(OP_WRITE, 4'($urandom), {pick_duty(), pick_duty()});
        end else begin
            send_request(OP_READ, 4'($urandom), $urandom);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        reg_access(1'b0, REG_PERIOD, '0);
        reg_access(1'b0, REG_FLOOR, '0);
        reg_access(1'b0, REG_CEILING, '0);
        send_request(OP_READ, 4'hF, 32'hFFFF_FFFF);
        repeat (2) send_request(OP_TICK, 4'($urandom), $urandom);
        // Motor 1 already sits on the floor, then single and combined key edges.
        send_request(OP_KEYS, 4'b0001, '0);
        send_request(OP_KEYS, 4'b1010, '0);
        send_request(OP_KEYS, 4'b1111, '0);
        send_request(OP_KEYS, 4'b0110, '0);
        wait_for_results();

        // Short frames: motor 1 duty zero, motor 2 duty far above the period.
        set_config(16'd4, 16'd0, 16'hFFFF);
        send_request(OP_WRITE, '0, 32'h00FF_0000);
        repeat (6) send_request(OP_TICK, 4'($urandom), $urandom);
        wait_for_results();

        // The period is cut below the count reached so far in the frame.
        set_config(16'd100, 16'd0, 16'hFFFF);
        send_request(OP_WRITE, '0, 32'h0001_0002);
        repeat (3) send_request(OP_TICK, '0, '0);
        wait_for_results();
        set_config(16'd2, 16'd0, 16'hFFFF);
        repeat (2) send_request(OP_TICK, '0, '0);
        wait_for_results();

        // A zero period ends a frame on every tick.
        set_config(16'd0, 16'd0, 16'hFFFF);
        repeat (2) send_request(OP_TICK, '0, '0);
        wait_for_results();

        // Floor above ceiling, then an all-ones word.
        set_config(16'd50, 16'd30, 16'd10);
        send_request(OP_KEYS, 4'b0011, '0);
        send_request(OP_KEYS, 4'b1100, '0);
        send_request(OP_WRITE, '0, 32'hFFFF_FFFF);
        send_request(OP_TICK, '0, '0);
        send_request(OP_READ, '0, '0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_for_results();
            case (p)
                1:       set_config(16'hFFFF, 16'h0000, 16'hFFFF);
                4:       set_config(16'd1, 16'hFFFF, 16'h0000);
                default: set_config(16'($urandom_range(2, 30)), 16'($urandom_range(0, 10)),
                                    16'($urandom_range(4, 40)));
            endcase
            if (p == 2 || p == PHASE_COUNT - 1) begin
                idle_pct <= 0;
            end else begin
                idle_pct <= $urandom_range(10, 40);
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Hold off once mid-phase until the pipe has emptied.
                if (p == 3 && n == PHASE_REQUESTS / 2) begin
                    wait_for_results();
                end
                send_random_request();
            end
        end
        wait_for_results();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
